// ===== rtl/distance_spike_reject_moving_average_assert.svh =====
// Assertion macros used by the distance filter checker.
`ifndef DISTANCE_SPIKE_REJECT_MOVING_AVERAGE_ASSERT_SVH
`define DISTANCE_SPIKE_REJECT_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define DSRMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define DSRMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsrma_pkg.sv =====
// Shared constants, types and helpers of the distance spike-reject filter.
`default_nettype none

package dsrma_pkg;

    localparam int WINDOW_DEPTH   = 4;
    localparam int DISTANCE_BITS  = 16;

    localparam int DIST_BITS      = DISTANCE_BITS;
    localparam int CFG_BITS       = 16;
    localparam int PASS_BITS      = 4;
    localparam int OUT_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CMP_BITS       = (DIST_BITS > CFG_BITS) ? DIST_BITS : CFG_BITS;
    localparam int SLOT_BITS      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_BITS       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS       = DIST_BITS + $clog2(WINDOW_DEPTH);

    // divider retires RADIX_BITS quotient bits per cycle
    localparam int RADIX_BITS     = 3;
    localparam int DIV_CYCLES     = (SUM_BITS + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIV_BITS       = DIV_CYCLES * RADIX_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

    localparam logic [CFG_BITS-1:0]  MIN_DIST_RESET  = CFG_BITS'(2);
    localparam logic [CFG_BITS-1:0]  MAX_DIST_RESET  = CFG_BITS'(400);
    localparam logic [CFG_BITS-1:0]  THRESHOLD_RESET = CFG_BITS'(100);
    localparam logic [PASS_BITS-1:0] PASS_RESET      = PASS_BITS'(3);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_DIST  = 2'd0,
        REG_MAX_DIST  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_PASS      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        logic [DIST_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] dividend;
        logic [OCC_BITS-1:0] divisor;
    } div_req_t;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [DIST_BITS-1:0] v);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dsrma_window_mem.sv =====
// Window storage: one write port, one registered read port.
`default_nettype none

module dsrma_window_mem (
    input  wire                          aclk,
    input  dsrma_pkg::mem_wr_t           wr,
    input  wire                          rd_en,
    input  wire [dsrma_pkg::SLOT_BITS-1:0] rd_addr,
    output logic [dsrma_pkg::DIST_BITS-1:0] rd_data
);
    import dsrma_pkg::*;

    logic [DIST_BITS-1:0] mem [WINDOW_DEPTH];
    logic [DIST_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/dsrma_divider.sv =====
// Iterative restoring divider: window sum by occupancy, a few bits per cycle.
`default_nettype none

module dsrma_divider (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  dsrma_pkg::div_req_t            req,
    output logic                           done,
    output logic [dsrma_pkg::DIST_BITS-1:0] quotient
);
    import dsrma_pkg::*;

    logic [DIV_BITS-1:0]     num_reg, num_next;
    logic [OCC_BITS:0]       rem_reg, rem_next;
    logic [OCC_BITS-1:0]     dvs_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    // shift dividend bits into the remainder, quotient bits into the vacated LSBs
    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        for (int k = 0; k < RADIX_BITS; k++) begin
            rem_next = {rem_next[OCC_BITS-1:0], num_next[DIV_BITS-1]};
            num_next = {num_next[DIV_BITS-2:0], 1'b0};
            if (rem_next >= {1'b0, dvs_reg}) begin
                rem_next    = rem_next - {1'b0, dvs_reg};
                num_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DIV_CYCLES);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= DIV_BITS'(req.dividend);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg[DIST_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/distance_spike_reject_moving_average.sv =====
// Distance filter top level: range check, spike rejection, moving average.
//
// Input channel s_valid/s_ready/s_distance takes one raw reading per request.
// Result channel m_valid/m_ready carries m_filtered_distance, m_spike_seen and
// m_reading_accepted. A reading outside [min, max] yields no result.
// The block handles one reading at a time; s_ready is high only while idle.
// From input acceptance to m_valid, a reading that stays out of the window
// passes through S_CHECK and S_EMIT; one that enters it passes through
// S_CHECK, S_UPDATE, S_DIVIDE and S_EMIT, waiting in S_DIVIDE for the
// iterative divider, which retires 3 quotient bits per cycle. A dropped
// reading returns from S_CHECK to S_IDLE and frees the input.
// The result sits in an output register, so the next reading is taken while
// it waits; a stalled receiver holds the result and stops the next reading
// only when it is ready to be presented.
// Reset (aresetn, synchronous, active low) empties the window, clears the
// average and spike run, and restores the register defaults (2, 400, 100, 3).
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
`default_nettype none

module distance_spike_reject_moving_average (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire [dsrma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire [dsrma_pkg::CFG_BITS-1:0]        cfg_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire [dsrma_pkg::DIST_BITS-1:0]       s_distance,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [dsrma_pkg::OUT_BITS-1:0]       m_filtered_distance,
    output logic                                 m_spike_seen,
    output logic                                 m_reading_accepted
);
    import dsrma_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_UPDATE = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_BITS-1:0]   min_reg, max_reg, thr_reg;
    logic [PASS_BITS-1:0]  pass_reg;
    logic [DIST_BITS-1:0]  din_reg;
    logic [DIST_BITS-1:0]  avg_reg, avg_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic [SLOT_BITS-1:0]  oldest_reg, oldest_next;
    logic [PASS_BITS-1:0]  run_reg, run_next;
    logic                  spike_reg, spike_next;
    logic                  accept_reg, accept_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]   m_dist_reg;
    logic                  m_spike_reg, m_accept_reg;
    logic                  load_out;

    logic [CMP_BITS-1:0]   d_w, diff_w;
    logic [DIST_BITS-1:0]  diff;
    logic                  in_range, is_spike;
    logic [PASS_BITS:0]    run_inc;
    logic                  full;
    logic [SLOT_BITS:0]    slot_sum;
    logic [SLOT_BITS-1:0]  append_slot;

    mem_wr_t               mem_wr;
    logic                  mem_rd_en;
    logic [DIST_BITS-1:0]  mem_rd_data;
    div_req_t              div_req;
    logic                  div_done;
    logic [DIST_BITS-1:0]  div_quot;

    dsrma_window_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (oldest_reg),
        .rd_data (mem_rd_data)
    );

    dsrma_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // decision datapath
    assign d_w      = CMP_BITS'(din_reg);
    assign in_range = (d_w >= CMP_BITS'(min_reg)) && (d_w <= CMP_BITS'(max_reg));
    assign diff     = (avg_reg > din_reg) ? (avg_reg - din_reg) : (din_reg - avg_reg);
    assign diff_w   = CMP_BITS'(diff);
    assign is_spike = diff_w > CMP_BITS'(thr_reg);
    assign run_inc  = {1'b0, run_reg} + (PASS_BITS + 1)'(1);
    assign full     = occ_reg == OCC_BITS'(WINDOW_DEPTH);

    // next free slot behind the oldest one, wrapped
    assign slot_sum = (SLOT_BITS + 1)'(oldest_reg) + (SLOT_BITS + 1)'(occ_reg);
    always_comb begin
        if (slot_sum >= (SLOT_BITS + 1)'(WINDOW_DEPTH)) begin
            append_slot = SLOT_BITS'(slot_sum - (SLOT_BITS + 1)'(WINDOW_DEPTH));
        end else begin
            append_slot = SLOT_BITS'(slot_sum);
        end
    end

    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next       = state_reg;
        avg_next         = avg_reg;
        sum_next         = sum_reg;
        occ_next         = occ_reg;
        oldest_next      = oldest_reg;
        run_next         = run_reg;
        spike_next       = spike_reg;
        accept_next      = accept_reg;
        m_valid_next     = m_valid_reg;
        mem_rd_en        = 1'b0;
        mem_wr.en        = 1'b0;
        mem_wr.addr      = append_slot;
        mem_wr.data      = din_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = occ_reg;
        s_ready          = state_reg == S_IDLE;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!in_range) begin
                    // drop: no result, no state change
                    state_next = S_IDLE;
                end else begin
                    spike_next = is_spike;
                    if (is_spike && (run_inc <= {1'b0, pass_reg})) begin
                        run_next    = run_inc[PASS_BITS-1:0];
                        accept_next = 1'b0;
                        state_next  = S_EMIT;
                    end else begin
                        run_next    = '0;
                        accept_next = 1'b1;
                        mem_rd_en   = 1'b1;
                        state_next  = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                mem_wr.en = 1'b1;
                if (full) begin
                    // replace the oldest reading and advance past it
                    mem_wr.addr = oldest_reg;
                    sum_next    = sum_reg - SUM_BITS'(mem_rd_data) + SUM_BITS'(din_reg);
                    if (oldest_reg == SLOT_BITS'(WINDOW_DEPTH - 1)) begin
                        oldest_next = '0;
                    end else begin
                        oldest_next = oldest_reg + SLOT_BITS'(1);
                    end
                end else begin
                    sum_next = sum_reg + SUM_BITS'(din_reg);
                    occ_next = occ_reg + OCC_BITS'(1);
                end
                div_req.start    = 1'b1;
                div_req.dividend = sum_next;
                div_req.divisor  = occ_next;
                state_next       = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (div_done) begin
                    avg_next   = div_quot;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            avg_reg     <= '0;
            sum_reg     <= '0;
            occ_reg     <= '0;
            oldest_reg  <= '0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            avg_reg     <= avg_next;
            sum_reg     <= sum_next;
            occ_reg     <= occ_next;
            oldest_reg  <= oldest_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= MIN_DIST_RESET;
            max_reg  <= MAX_DIST_RESET;
            thr_reg  <= THRESHOLD_RESET;
            pass_reg <= PASS_RESET;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_MIN_DIST:  min_reg  <= cfg_data;
                REG_MAX_DIST:  max_reg  <= cfg_data;
                REG_THRESHOLD: thr_reg  <= cfg_data;
                REG_PASS:      pass_reg <= cfg_data[PASS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            din_reg <= s_distance;
        end
        spike_reg  <= spike_next;
        accept_reg <= accept_next;
        if (load_out) begin
            m_dist_reg   <= to_out(avg_reg);
            m_spike_reg  <= spike_reg;
            m_accept_reg <= accept_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_filtered_distance = m_dist_reg;
    assign m_spike_seen        = m_spike_reg;
    assign m_reading_accepted  = m_accept_reg;

endmodule

`default_nettype wire

// ===== rtl/dsrma_checker.sv =====
// Port-level checker for the distance filter, bound to the top level.
`default_nettype none
`include "distance_spike_reject_moving_average_assert.svh"

module dsrma_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [dsrma_pkg::OUT_BITS-1:0]     m_filtered_distance,
    input wire                               m_spike_seen,
    input wire                               m_reading_accepted
);
    import dsrma_pkg::*;

    `DSRMA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_filtered_distance) && $stable(m_spike_seen) && $stable(m_reading_accepted), "result changed while stalled")
    `DSRMA_ASSERT_IMPL(a_reject_is_spike, m_valid && !m_reading_accepted, m_spike_seen, "reading rejected without a spike")
    `DSRMA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second request taken while busy")
    `DSRMA_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready, !$rose(m_valid), "result raised right after request")

endmodule

bind distance_spike_reject_moving_average dsrma_checker u_checker (.*);

`default_nettype wire
